FILE: hw/rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with search unit.
package bdq_pkg;

    // Default number of stored words
    localparam int BDQ_DEPTH = 16;

    // Fixed field widths of the request and result
    localparam int OP_W   = 3;
    localparam int WORD_W = 32;
    localparam int POS_W  = 8;
    localparam int OCC_W  = 9;

    // Operation codes (code 7 is unused and answers ok with no change)
    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_FRONT  = 3'd2,
        OP_POP_BACK   = 3'd3,
        OP_SEARCH     = 3'd4,
        OP_MIN        = 3'd5,
        OP_MAX        = 3'd6
    } bdq_op_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } bdq_status_t;

    // Operation class as seen by the controller
    typedef enum logic [1:0] {
        KIND_PUSH,
        KIND_POP,
        KIND_SCAN,
        KIND_NONE
    } bdq_kind_t;

    // Controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_DISPATCH,
        S_POP_WAIT,
        S_SCAN
    } bdq_state_t;

    // Request payload
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] value;
    } bdq_req_t;

    // Result payload
    typedef struct packed {
        bdq_status_t              status;
        logic signed [WORD_W-1:0] data;
        logic [POS_W-1:0]         position;
        logic [OCC_W-1:0]         occupancy;
    } bdq_rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;      // capture the incoming request
        logic dispatch;  // perform push/pop bookkeeping, issue first read
        logic scan;      // one step of the ring walk
        logic rsp_pop;   // result takes the popped word
        logic rsp_scan;  // result takes the walk outcome
        logic finish;    // register the result
    } bdq_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        bdq_kind_t kind;
        logic      empty;
        logic      last;  // word under compare is the back entry
        logic      hit;   // search match on the word under compare
    } bdq_stat_t;

endpackage

FILE: hw/rtl/bdq_ctrl.sv
// Controller state machine of the deque: sequences dispatch, pop read and ring walk.
module bdq_ctrl
    import bdq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    input  bdq_stat_t stat,
    output bdq_cmd_t  cmd,
    output logic      busy,
    output logic      done
);

    bdq_state_t state_reg;
    bdq_state_t state_next;
    logic       done_reg;
    logic       done_next;

    // State and strobe registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                if (stat.kind == KIND_POP && !stat.empty)
                begin
                    state_next = S_POP_WAIT;
                end
                else if (stat.kind == KIND_SCAN && !stat.empty)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_POP_WAIT:
            begin
                state_next = S_IDLE;
            end
            S_SCAN:
            begin
                if (stat.hit || stat.last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            S_DISPATCH:
            begin
                cmd.dispatch = 1'b1;
                cmd.finish   = !((stat.kind == KIND_POP || stat.kind == KIND_SCAN)
                                 && !stat.empty);
            end
            S_POP_WAIT:
            begin
                cmd.rsp_pop = 1'b1;
                cmd.finish  = 1'b1;
            end
            S_SCAN:
            begin
                cmd.scan     = 1'b1;
                cmd.rsp_scan = 1'b1;
                cmd.finish   = stat.hit || stat.last;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    assign done_next = cmd.finish;
    assign done      = done_reg;

endmodule

FILE: hw/rtl/bdq_dpath.sv
// Datapath of the deque: ring storage, front pointer, fill count, walk and result.
module bdq_dpath
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  bdq_req_t  req,
    input  bdq_cmd_t  cmd,
    output bdq_stat_t stat,
    output bdq_rsp_t  rsp
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;

    // Storage and registers
    logic signed [WORD_W-1:0] mem [DEPTH];
    bdq_req_t                 req_reg;
    logic [PW-1:0]            front_reg;
    logic [PW-1:0]            front_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [CW-1:0]            idx_reg;
    logic [CW-1:0]            idx_next;
    logic signed [WORD_W-1:0] rd_data_reg;
    logic signed [WORD_W-1:0] acc_reg;
    logic signed [WORD_W-1:0] acc_next;
    bdq_rsp_t                 rsp_reg;
    bdq_rsp_t                 rsp_next;

    bdq_kind_t     kind;
    logic          full;
    logic          empty;
    logic [CW-1:0] rd_off;
    logic [SW-1:0] rd_sum;
    logic [PW-1:0] rd_addr;
    logic [SW-1:0] wb_sum;
    logic [PW-1:0] wr_addr;
    logic          wr_en;
    logic          first;
    logic          take;
    logic [CW-1:0] idx_minus;

    // Operation class of the held request
    always_comb
    begin
        if (req_reg.op inside {OP_PUSH_FRONT, OP_PUSH_BACK})
        begin
            kind = KIND_PUSH;
        end
        else if (req_reg.op inside {OP_POP_FRONT, OP_POP_BACK})
        begin
            kind = KIND_POP;
        end
        else if (req_reg.op inside {OP_SEARCH, OP_MIN, OP_MAX})
        begin
            kind = KIND_SCAN;
        end
        else
        begin
            kind = KIND_NONE;
        end
    end

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // Read address: back entry for pop back, otherwise front plus walk index
    assign rd_off  = (cmd.dispatch && req_reg.op == OP_POP_BACK)
                     ? count_reg - CW'(1) : idx_reg;
    assign rd_sum  = SW'(front_reg) + SW'(rd_off);
    assign rd_addr = (rd_sum >= SW'(DEPTH)) ? PW'(rd_sum - SW'(DEPTH)) : PW'(rd_sum);

    // Write address: slot before the front, or slot after the back
    assign wb_sum  = SW'(front_reg) + SW'(count_reg);
    assign wr_addr = (req_reg.op == OP_PUSH_FRONT) ? front_next
                     : ((wb_sum >= SW'(DEPTH)) ? PW'(wb_sum - SW'(DEPTH)) : PW'(wb_sum));
    assign wr_en   = cmd.dispatch && kind == KIND_PUSH && !full;

    // Pointer, count and walk index updates
    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        idx_next   = idx_reg;
        if (cmd.load)
        begin
            idx_next = '0;
        end
        if (cmd.dispatch || cmd.scan)
        begin
            idx_next = idx_reg + CW'(1);
        end
        if (cmd.dispatch && kind == KIND_PUSH && !full)
        begin
            count_next = count_reg + CW'(1);
            if (req_reg.op == OP_PUSH_FRONT)
            begin
                front_next = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - PW'(1);
            end
        end
        if (cmd.dispatch && kind == KIND_POP && !empty)
        begin
            count_next = count_reg - CW'(1);
            if (req_reg.op == OP_POP_FRONT)
            begin
                front_next = (front_reg == PW'(DEPTH - 1)) ? '0 : front_reg + PW'(1);
            end
        end
    end

    // Walk compare: first word seeds the running min or max
    assign first = (idx_reg == CW'(1));
    assign take  = (req_reg.op == OP_MIN) ? (rd_data_reg < acc_reg)
                                          : (rd_data_reg > acc_reg);
    assign acc_next  = (first || take) ? rd_data_reg : acc_reg;
    assign idx_minus = idx_reg - CW'(1);

    // Result selection
    always_comb
    begin
        rsp_next           = '0;
        rsp_next.status    = ST_OK;
        rsp_next.occupancy = OCC_W'(count_next);
        if (cmd.rsp_pop)
        begin
            rsp_next.data = rd_data_reg;
        end
        else if (cmd.rsp_scan)
        begin
            if (req_reg.op == OP_SEARCH)
            begin
                if (stat.hit)
                begin
                    rsp_next.position = POS_W'(idx_minus);
                end
                else
                begin
                    rsp_next.status = ST_NOT_FOUND;
                end
            end
            else
            begin
                rsp_next.data = acc_next;
            end
        end
        else
        begin
            case (kind)
                KIND_PUSH:
                begin
                    rsp_next.status = full ? ST_FULL : ST_OK;
                end
                KIND_POP:
                begin
                    rsp_next.status = ST_EMPTY;
                end
                KIND_SCAN:
                begin
                    rsp_next.status = (req_reg.op == OP_SEARCH) ? ST_NOT_FOUND : ST_EMPTY;
                end
                default:
                begin
                    rsp_next.status = ST_OK;
                end
            endcase
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            count_reg <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg <= req;
        end
        if (cmd.scan)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Ring storage: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= req_reg.value;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign stat.kind  = kind;
    assign stat.empty = empty;
    assign stat.last  = (idx_reg == count_reg);
    assign stat.hit   = (req_reg.op == OP_SEARCH) && (rd_data_reg == req_reg.value);
    assign rsp        = rsp_reg;

endmodule

FILE: hw/rtl/bounded_deque_with_search_unit.sv
// Top level of the bounded deque with search: controller plus datapath.
//
//   channel   ports               handshake
//   request   req (op, value)     taken on a clock edge with start high, busy low
//   result    rsp (status, data,  valid for the one cycle that done is high;
//             position, occupancy) no back-pressure
//
// After the request edge the controller dispatches. Pushes, unused codes and failed
// operations finish in dispatch, a pop finishes in a read-wait state, and search,
// min and max walk the entries visited (up to the occupancy, at most DEPTH). The walk
// is set by the single read port of the ring storage, one entry per cycle.
// A new request may be taken in the done cycle. Reset clears the front pointer
// and fill count at once; stored words need no clearing.
module bounded_deque_with_search_unit
    import bdq_pkg::*;
#(
    parameter int DEPTH = BDQ_DEPTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    output logic     busy,
    input  bdq_req_t req,
    output logic     done,
    output bdq_rsp_t rsp
);

    bdq_cmd_t  cmd;
    bdq_stat_t stat;

    // Sequencer
    bdq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Storage, pointers and result
    bdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (rsp)
    );

endmodule

FILE: tb/bdq_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the bounded deque: mirrors the ring store and compares every result.
module bdq_result_checker
    import bdq_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  logic     busy,
    input  bdq_req_t req,
    input  logic     done,
    input  bdq_rsp_t rsp,
    output int       errors,
    output int       waiting,
    output int       checked,
    output int       full_hits,
    output int       empty_hits,
    output int       misses
);

    localparam int DEPTH     = BDQ_DEPTH;
    localparam int PRINT_CAP = 60;

    // Mirror of the ring: front index and number of words held
    logic signed [WORD_W-1:0] words [DEPTH];
    int                       head;
    int                       held;

    // Results owed by the block, oldest first
    bdq_rsp_t                 owed_results [$];

    // Apply one request to the mirror and return the result it owes
    function automatic bdq_rsp_t deque_apply(bdq_req_t r);
        bdq_rsp_t                 res;
        logic signed [WORD_W-1:0] best;
        logic signed [WORD_W-1:0] w;
        int                       k;
        res        = '0;
        res.status = ST_OK;
        case (r.op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
            begin
                if (held >= DEPTH)
                    res.status = ST_FULL;
                else if (r.op == OP_PUSH_FRONT)
                begin
                    head        = (head + DEPTH - 1) % DEPTH;
                    words[head] = r.value;
                    held++;
                end
                else
                begin
                    words[(head + held) % DEPTH] = r.value;
                    held++;
                end
            end
            OP_POP_FRONT, OP_POP_BACK:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else if (r.op == OP_POP_FRONT)
                begin
                    res.data = words[head];
                    head     = (head + 1) % DEPTH;
                    held--;
                end
                else
                begin
                    res.data = words[(head + held - 1) % DEPTH];
                    held--;
                end
            end
            OP_SEARCH:
            begin
                // first match counted from the front; a miss leaves position zero
                res.status = ST_NOT_FOUND;
                for (k = 0; k < held; k++)
                begin
                    if (words[(head + k) % DEPTH] == r.value)
                    begin
                        res.status   = ST_OK;
                        res.position = POS_W'(k);
                        break;
                    end
                end
            end
            OP_MIN, OP_MAX:
            begin
                if (held == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    best = words[head];
                    for (k = 1; k < held; k++)
                    begin
                        w = words[(head + k) % DEPTH];
                        if (r.op == OP_MIN ? (w < best) : (w > best))
                            best = w;
                    end
                    res.data = best;
                end
            end
            default:
            begin
                // unused code: no change, plain ok
            end
        endcase
        res.occupancy = OCC_W'(held);
        return res;
    endfunction

    // One line per mismatch, printing capped so a broken block cannot flood the log
    task automatic log_mismatch(string what);
        if (errors < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, what);
        errors++;
    endtask

    // Compare each strobed result with the oldest owed one, then record new requests
    always @(posedge clk or negedge rst_n)
    begin : watch
        bdq_rsp_t want;
        if (!rst_n)
        begin
            head = 0;
            held = 0;
            owed_results.delete();
            waiting = 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_results.size() == 0)
                    log_mismatch($sformatf("result with nothing owed (status %0d, data %0d)",
                                           rsp.status, rsp.data));
                else
                begin
                    want = owed_results.pop_front();
                    checked++;
                    case (want.status)
                        ST_FULL:      full_hits++;
                        ST_EMPTY:     empty_hits++;
                        ST_NOT_FOUND: misses++;
                        default:      ;
                    endcase
                    if (rsp.status !== want.status)
                        log_mismatch($sformatf("status expected %0d, got %0d",
                                               want.status, rsp.status));
                    if (rsp.data !== want.data)
                        log_mismatch($sformatf("data expected %0d, got %0d",
                                               want.data, rsp.data));
                    if (rsp.position !== want.position)
                        log_mismatch($sformatf("position expected %0d, got %0d",
                                               want.position, rsp.position));
                    if (rsp.occupancy !== want.occupancy)
                        log_mismatch($sformatf("occupancy expected %0d, got %0d",
                                               want.occupancy, rsp.occupancy));
                end
            end
            if (start && !busy)
                owed_results.push_back(deque_apply(req));
            waiting = owed_results.size();
        end
    end

endmodule

FILE: tb/tb_bounded_deque_with_search_unit.sv
`timescale 1ns / 1ps
// Testbench top for the bounded deque with search: clock, reset, request stimulus and verdict.
module tb_bounded_deque_with_search_unit;
    import bdq_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_REQUESTS = 450;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 40;
    localparam int RECENT_KEEP     = 24;

    typedef enum {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_t;

    logic     clk;
    logic     rst_n;
    logic     start;
    logic     busy;
    logic     done;
    bdq_req_t req;
    bdq_rsp_t rsp;

    int errors;
    int waiting;
    int checked;
    int full_hits;
    int empty_hits;
    int misses;
    int cycles;
    int sent;

    // Recently pushed words, used to aim searches at hits
    logic signed [WORD_W-1:0] recent [$];

    bounded_deque_with_search_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    bdq_result_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .errors     (errors),
        .waiting    (waiting),
        .checked    (checked),
        .full_hits  (full_hits),
        .empty_hits (empty_hits),
        .misses     (misses)
    );

    // 2 ns clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Timed out after %0d cycles with %0d results owed", cycles, waiting);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Drive one request and hold it until the block takes it
    task automatic send(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] v);
        @(negedge clk);
        start <= 1'b1;
        req   <= '{op: op, value: v};
        if (op == OP_PUSH_FRONT || op == OP_PUSH_BACK)
        begin
            recent.push_back(v);
            if (recent.size() > RECENT_KEEP)
                void'(recent.pop_front());
        end
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic idle(int n);
        repeat (n)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
    endtask

    // Word choice: mostly random, some small values for duplicates, extremes, recent words
    function automatic logic signed [WORD_W-1:0] pick_value(bit aim_at_hit);
        int sel;
        int small_v;
        sel = $urandom_range(0, 9);
        if (recent.size() != 0 && (aim_at_hit ? sel < 7 : sel >= 8))
            return recent[$urandom_range(0, recent.size() - 1)];
        if (sel == 6)
        begin
            small_v = $urandom_range(0, 16);
            return small_v - 8;
        end
        if (sel == 7)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'sh7FFFFFFF;
                1:       return 32'sh80000000;
                2:       return 0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    // One random request, op mix skewed by the traffic mode
    task automatic send_random(traffic_mode_t mode);
        int p;
        int push_pct;
        int pop_pct;
        p        = $urandom_range(0, 99);
        push_pct = (mode == MODE_FILL) ? 65 : (mode == MODE_DRAIN) ? 15 : 35;
        pop_pct  = (mode == MODE_DRAIN) ? 60 : (mode == MODE_FILL) ? 10 : 30;
        if (p < push_pct)
            send($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value(1'b0));
        else if (p < push_pct + pop_pct)
            send($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK, $urandom);
        else
        begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: send(OP_SEARCH, pick_value(1'b1));
                5, 6:          send(OP_MIN, $urandom);
                7, 8:          send(OP_MAX, $urandom);
                default:       send(OP_UNUSED, $urandom);
            endcase
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        traffic_mode_t            mode;
        int                       mode_left;
        int                       remaining;
        int                       burst;
        int                       i;
        logic signed [WORD_W-1:0] last_word;

        rst_n = 1'b0;
        start = 1'b0;
        req   = '0;
        sent  = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty store: every failing operation and the unused code
        send(OP_POP_FRONT, 0);
        send(OP_POP_BACK, 0);
        send(OP_MIN, 0);
        send(OP_MAX, 0);
        send(OP_SEARCH, 0);
        send(OP_UNUSED, -1);

        // Extremes at both ends, with a duplicate for first-match search
        send(OP_PUSH_BACK, 32'sh7FFFFFFF);
        send(OP_PUSH_FRONT, 32'sh80000000);
        send(OP_PUSH_BACK, -1);
        send(OP_PUSH_FRONT, 0);
        send(OP_PUSH_BACK, -1);
        send(OP_MIN, 0);
        send(OP_MAX, 0);
        send(OP_SEARCH, -1);
        send(OP_SEARCH, 12345);
        send(OP_POP_FRONT, 0);
        send(OP_POP_BACK, 0);

        // Fill to the brim, push into a full store, search the back entry
        for (i = 0; i < 13; i++)
        begin
            last_word = i * 7919 - 50000;
            send(OP_PUSH_BACK, last_word);
        end
        send(OP_PUSH_FRONT, 1);
        send(OP_PUSH_BACK, 1);
        send(OP_SEARCH, last_word);
        send(OP_MAX, 0);

        // Random traffic in bursts; modes steer the store between full and empty
        mode      = MODE_DRAIN;
        mode_left = $urandom_range(10, 40);
        remaining = RANDOM_REQUESTS;
        while (remaining > 0)
        begin
            burst = $urandom_range(1, 16);
            if (burst > remaining)
                burst = remaining;
            repeat (burst)
            begin
                if (mode_left == 0)
                begin
                    mode      = traffic_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 40);
                end
                send_random(mode);
                mode_left--;
            end
            remaining -= burst;
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 12));
        end
        idle(1);

        // Let the last results come home, then a quiet tail
        while (waiting != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Sent %0d requests, checked %0d results in %0d cycles", sent, checked, cycles);
        $display("Outcomes seen: %0d full pushes, %0d empty-store ops, %0d search misses",
                 full_hits, empty_hits, misses);
        if (errors == 0 && waiting == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
